// File: hw/rtl/desp_pkg.sv
`timescale 1ns / 1ps
// desp_pkg: shared types and constants for the directory entry stream parser
// no dependencies

package desp_pkg;

    localparam int HDR_BYTES = 8;
    localparam int NRS_W     = 17;
    localparam int TDATA_W   = 112;

    localparam logic [15:0] ORDINAL_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_HEADER    = 2'd0,
        KIND_NAME      = 2'd1,
        KIND_MALFORMED = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t        kind;
        logic [31:0]  entry_inode;
        logic [15:0]  record_length;
        logic [7:0]   name_length;
        logic [7:0]   type_code;
        logic [15:0]  entry_ordinal;
        logic [9:0]   entry_offset;
        logic [7:0]   name_char;
        logic [7:0]   name_position;
        logic         name_last;
        logic         is_target;
    } result_t;

endpackage

// File: hw/rtl/desp_parse.sv
`timescale 1ns / 1ps
// desp_parse: per-byte directory entry walker with its parse state registers
// depends on desp_pkg

module desp_parse #(
    parameter int BLOCK_BYTES = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         data_byte,
    input  logic               dir_start,
    input  logic [15:0]        target_ordinal,
    output logic               res_valid,
    output desp_pkg::result_t  res
);
    import desp_pkg::*;

    localparam int OFF_W = $clog2(BLOCK_BYTES);
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(BLOCK_BYTES - 1);
    localparam logic [NRS_W-1:0] HDR_LIMIT = NRS_W'(BLOCK_BYTES - HDR_BYTES);

    logic [OFF_W-1:0] byte_in_block_reg, byte_in_block_next;
    logic [NRS_W-1:0] nrs_reg, nrs_next;
    logic [55:0]      shift_reg, shift_next;
    logic [15:0]      count_reg, count_next;
    logic [7:0]       nbl_reg, nbl_next;
    logic [7:0]       nidx_reg, nidx_next;
    logic             halted_reg, halted_next;
    logic             live_reg, live_next;

    logic [OFF_W-1:0] off_cur;
    logic             blk_start;
    logic [NRS_W-1:0] nrs_cur;
    logic [15:0]      count_cur;
    logic [7:0]       nbl_cur;
    logic [7:0]       nidx_cur;
    logic             halted_cur;
    logic             live_cur;
    logic [NRS_W:0]   diff;
    logic             in_hdr;
    logic             hdr_done;
    logic [63:0]      hdr;
    logic [31:0]      ino;
    logic [15:0]      rec;
    logic [7:0]       nl;
    logic [15:0]      rec_room;
    logic [NRS_W-1:0] blk_room;
    logic [7:0]       eff_a;
    logic [7:0]       eff;

    always_comb
    begin
        off_cur    = dir_start ? '0 : byte_in_block_reg;
        blk_start  = (off_cur == '0);
        nrs_cur    = blk_start ? '0 : nrs_reg;
        halted_cur = blk_start ? 1'b0 : halted_reg;
        nbl_cur    = blk_start ? '0 : nbl_reg;
        nidx_cur   = blk_start ? '0 : nidx_reg;
        live_cur   = blk_start ? 1'b0 : live_reg;
        count_cur  = dir_start ? '0 : count_reg;

        diff     = {1'b0, NRS_W'(off_cur)} - {1'b0, nrs_cur};
        in_hdr   = !halted_cur && !diff[NRS_W] && (diff[NRS_W-1:0] < NRS_W'(HDR_BYTES));
        hdr_done = in_hdr && (diff[2:0] == 3'd7);

        hdr = {data_byte, shift_reg};
        ino = hdr[31:0];
        rec = hdr[47:32];
        nl  = hdr[55:48];

        // name bytes stop at record end or block end
        rec_room = rec - 16'(HDR_BYTES);
        blk_room = HDR_LIMIT - nrs_cur;
        eff_a    = (rec_room < 16'(nl)) ? rec_room[7:0] : nl;
        eff      = (blk_room < NRS_W'(eff_a)) ? blk_room[7:0] : eff_a;

        byte_in_block_next = (off_cur == OFF_LAST) ? '0 : off_cur + 1'b1;
        nrs_next    = nrs_cur;
        shift_next  = in_hdr ? hdr[63:8] : shift_reg;
        count_next  = count_cur;
        nbl_next    = nbl_cur;
        nidx_next   = nidx_cur;
        halted_next = halted_cur;
        live_next   = live_cur;

        res_valid         = 1'b0;
        res               = '0;
        res.entry_inode   = ino;
        res.record_length = rec;
        res.name_length   = nl;
        res.type_code     = hdr[63:56];
        res.entry_ordinal = count_cur;
        res.entry_offset  = nrs_cur[9:0];

        if (hdr_done)
        begin
            if (rec < 16'(HDR_BYTES))
            begin
                res_valid   = 1'b1;
                res.kind    = KIND_MALFORMED;
                halted_next = 1'b1;
                live_next   = 1'b0;
                nbl_next    = '0;
            end
            else
            begin
                nrs_next  = nrs_cur + NRS_W'(rec);
                nidx_next = '0;
                if (ino != '0)
                begin
                    res_valid     = 1'b1;
                    res.kind      = KIND_HEADER;
                    res.is_target = (count_cur == target_ordinal);
                    if (count_cur != ORDINAL_MAX)
                    begin
                        count_next = count_cur + 1'b1;
                    end
                    live_next = 1'b1;
                    nbl_next  = eff;
                end
                else
                begin
                    live_next = 1'b0;
                    nbl_next  = '0;
                end
            end
        end
        else if (!in_hdr && !halted_cur && live_cur && (nbl_cur != '0))
        begin
            res_valid         = 1'b1;
            res               = '0;
            res.kind          = KIND_NAME;
            res.name_char     = data_byte;
            res.name_position = nidx_cur;
            res.name_last     = (nbl_cur == 8'd1);
            nbl_next          = nbl_cur - 1'b1;
            nidx_next         = nidx_cur + 1'b1;
        end

        if (!step)
        begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_block_reg <= '0;
            nrs_reg           <= '0;
            shift_reg         <= '0;
            count_reg         <= '0;
            nbl_reg           <= '0;
            nidx_reg          <= '0;
            halted_reg        <= 1'b0;
            live_reg          <= 1'b0;
        end
        else if (step)
        begin
            byte_in_block_reg <= byte_in_block_next;
            nrs_reg           <= nrs_next;
            shift_reg         <= shift_next;
            count_reg         <= count_next;
            nbl_reg           <= nbl_next;
            nidx_reg          <= nidx_next;
            halted_reg        <= halted_next;
            live_reg          <= live_next;
        end
    end

`ifndef SYNTH
    a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (!live_reg && (nbl_reg == '0)))
        else $error("halted block still has name bytes pending");

    a_pending_live: assert property (@(posedge clk) disable iff (!rst_n)
        (nbl_reg != '0) |-> live_reg)
        else $error("name bytes pending without a live entry");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.kind == KIND_NAME) && res.name_last) |=> (nbl_reg == '0))
        else $error("name bytes left after last name byte");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(count_reg) && $stable(byte_in_block_reg)))
        else $error("parse state moved without a step");
`endif

endmodule

// File: hw/rtl/directory_entry_stream_parser.sv
`timescale 1ns / 1ps
// directory_entry_stream_parser: one data byte per transfer in, entry headers and name bytes out,
// and a malformed marker for a record shorter than its header; each result passes the input
// register, then a combinational parse into the result register, on its way to the master side
// throughput: one byte per cycle; a stalled result holds the slave side once one byte is buffered
// reset: rst_n clears the byte counter, parse state, entry count and target_ordinal
// depends on desp_pkg and desp_parse

module directory_entry_stream_parser #(
    parameter int BLOCK_BYTES = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // data_byte
    input  logic                             s_tuser,   // dir_start
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // entry_inode, record_length, name_length, type_code, entry_ordinal,
    // entry_offset, name_char, name_position, is_target, zero pad
    output logic [desp_pkg::TDATA_W-1:0]     m_tdata,
    output logic [1:0]                       m_tuser,   // kind
    output logic                             m_tlast,   // name_last
    input  logic                             cfg_wr_en,
    input  logic [15:0]                      cfg_wr_data // target_ordinal
);
    import desp_pkg::*;

    logic              in_valid_reg;
    logic [7:0]        in_data_reg;
    logic              in_start_reg;
    logic [15:0]       target_reg;
    logic              out_valid_reg;
    result_t           out_res_reg;
    logic              step;
    logic              res_valid;
    result_t           res;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    desp_parse #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_parse (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .data_byte      (in_data_reg),
        .dir_start      (in_start_reg),
        .target_ordinal (target_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            target_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                target_reg <= cfg_wr_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (step)
            begin
                out_valid_reg <= res_valid;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (step && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.name_last;
    assign m_tdata  = {5'd0,
                       out_res_reg.is_target,
                       out_res_reg.name_position,
                       out_res_reg.name_char,
                       out_res_reg.entry_offset,
                       out_res_reg.entry_ordinal,
                       out_res_reg.type_code,
                       out_res_reg.name_length,
                       out_res_reg.record_length,
                       out_res_reg.entry_inode};

endmodule
